// ===== rtl/core/ofe_pkg.sv =====
// Shared widths, field offsets, codes and item types for the order-flow event encoder.
package ofe_pkg;

  localparam int unsigned PRICE_W = 47;
  localparam int unsigned QTY_W   = 40;
  localparam int unsigned TIME_W  = 53;
  localparam int unsigned AMT_W   = QTY_W + 1;
  localparam int unsigned DIFF_W  = QTY_W + 1;
  localparam int unsigned IMB_W   = QTY_W + 2;

  // Input tdata layout, lowest bit first.
  localparam int unsigned IN_TIME_LO  = 0;
  localparam int unsigned IN_BIM_LO   = IN_TIME_LO + TIME_W;
  localparam int unsigned IN_TPX_LO   = IN_BIM_LO + 1;
  localparam int unsigned IN_TQTY_LO  = IN_TPX_LO + PRICE_W;
  localparam int unsigned IN_BPX_LO   = IN_TQTY_LO + QTY_W;
  localparam int unsigned IN_BQTY_LO  = IN_BPX_LO + PRICE_W;
  localparam int unsigned IN_APX_LO   = IN_BQTY_LO + QTY_W;
  localparam int unsigned IN_AQTY_LO  = IN_APX_LO + PRICE_W;
  localparam int unsigned IN_USED_W   = IN_AQTY_LO + QTY_W;
  localparam int unsigned IN_DATA_W   = ((IN_USED_W + 7) / 8) * 8;

  // Output tdata layout, lowest bit first.
  localparam int unsigned OUT_TIME_LO = 0;
  localparam int unsigned OUT_PX_LO   = OUT_TIME_LO + TIME_W;
  localparam int unsigned OUT_AMT_LO  = OUT_PX_LO + PRICE_W;
  localparam int unsigned OUT_USED_W  = OUT_AMT_LO + AMT_W;
  localparam int unsigned OUT_DATA_W  = ((OUT_USED_W + 7) / 8) * 8;
  localparam int unsigned OUT_PAD_W   = OUT_DATA_W - OUT_USED_W;

  typedef enum logic {
    CMD_TRADE = 1'b0,
    CMD_QUOTE = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_BUY     = 2'd0,
    KIND_SELL    = 2'd1,
    KIND_IMB_POS = 2'd2,
    KIND_IMB_NEG = 2'd3
  } kind_e;

  typedef struct packed {
    cmd_e                 cmd;
    logic [TIME_W-1:0]    event_time;
    logic                 buyer_is_maker;
    logic [PRICE_W-1:0]   trade_price;
    logic [QTY_W-1:0]     trade_qty;
    logic [PRICE_W-1:0]   bid_price;
    logic [QTY_W-1:0]     bid_qty;
    logic [PRICE_W-1:0]   ask_price;
    logic [QTY_W-1:0]     ask_qty;
  } item_t;

  typedef struct packed {
    logic [PRICE_W-1:0]   bid_price;
    logic [QTY_W-1:0]     bid_qty;
    logic [PRICE_W-1:0]   ask_price;
    logic [QTY_W-1:0]     ask_qty;
    logic                 seeded;
    logic [TIME_W-1:0]    last_time;
  } book_t;

  typedef struct packed {
    logic [TIME_W-1:0]    out_time;
    kind_e                event_kind;
    logic [PRICE_W-1:0]   out_price;
    logic [AMT_W-1:0]     out_amount;
  } result_t;

endpackage

// ===== rtl/core/ofe_calc.sv =====
// Combinational event computation for one registered item against the stored book.
module ofe_calc
  import ofe_pkg::*;
(
  input  item_t   item_i,
  input  book_t   book_i,
  output logic    emit_o,
  output result_t result_o
);

  logic signed [DIFF_W-1:0] d_bid;
  logic signed [DIFF_W-1:0] d_ask;
  logic signed [IMB_W-1:0]  imb;
  logic        [IMB_W-1:0]  imb_abs;
  logic        [TIME_W-1:0] bumped_time;

  // Side change: full new quantity on a price move, else the quantity delta.
  always_comb begin
    if (item_i.bid_price != book_i.bid_price) begin
      d_bid = $signed({1'b0, item_i.bid_qty});
    end else begin
      d_bid = $signed({1'b0, item_i.bid_qty}) - $signed({1'b0, book_i.bid_qty});
    end
    if (item_i.ask_price != book_i.ask_price) begin
      d_ask = $signed({1'b0, item_i.ask_qty});
    end else begin
      d_ask = $signed({1'b0, item_i.ask_qty}) - $signed({1'b0, book_i.ask_qty});
    end
  end

  assign imb     = {d_bid[DIFF_W-1], d_bid} - {d_ask[DIFF_W-1], d_ask};
  assign imb_abs = imb[IMB_W-1] ? (~imb + 1'b1) : imb;

  // Bump to last + 1 when not strictly later; hold at the top value.
  always_comb begin
    if (item_i.event_time > book_i.last_time) begin
      bumped_time = item_i.event_time;
    end else if (book_i.last_time == {TIME_W{1'b1}}) begin
      bumped_time = book_i.last_time;
    end else begin
      bumped_time = book_i.last_time + 1'b1;
    end
  end

  always_comb begin
    result_o.out_time = bumped_time;
    case (item_i.cmd)
      CMD_TRADE: begin
        emit_o              = 1'b1;
        result_o.event_kind = item_i.buyer_is_maker ? KIND_SELL : KIND_BUY;
        result_o.out_price  = item_i.trade_price;
        result_o.out_amount = {1'b0, item_i.trade_qty};
      end
      CMD_QUOTE: begin
        emit_o              = book_i.seeded && (imb != '0);
        result_o.event_kind = imb[IMB_W-1] ? KIND_IMB_NEG : KIND_IMB_POS;
        result_o.out_price  = item_i.bid_price;
        result_o.out_amount = imb_abs[AMT_W-1:0];
      end
      default: begin
        emit_o              = 1'b0;
        result_o.event_kind = KIND_BUY;
        result_o.out_price  = item_i.trade_price;
        result_o.out_amount = {1'b0, item_i.trade_qty};
      end
    endcase
  end

endmodule

// ===== rtl/core/order_flow_event_encoder.sv =====
// Order-flow event encoder: trades and best bid/ask quotes in, typed events out.
// Path: an item passes the input register, then the result register behind
// the event logic. Throughput: one item per cycle while the result slot is free
// or the item makes no event; the only loop is the book/last-time update,
// which closes through the event logic.
// Reset clears both valid flags, the stored quote, the seeded flag and the last time.
module order_flow_event_encoder
  import ofe_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Input stream
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // tdata from bit 0: event_time, buyer_is_maker, trade_price, trade_qty,
  //   bid_price, bid_qty, ask_price, ask_qty, unused pad
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  input  logic                  s_axis_tuser_i,   // cmd
  // Output stream
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // tdata from bit 0: out_time, out_price, out_amount, zero pad
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  output logic [1:0]            m_axis_tuser_o    // event_kind
);

  // Input register stage.
  logic    in_valid_q;
  item_t   in_item_q;
  item_t   in_item_d;

  // Stored book and event clock.
  book_t   book_q;
  book_t   book_d;

  // Result register stage.
  logic    out_valid_q;
  logic    out_valid_d;
  result_t out_res_q;

  logic    emit;
  result_t calc_res;
  logic    out_free;
  logic    advance;
  logic    in_xfer;

  // Unpack the input transfer.
  always_comb begin
    in_item_d.cmd            = cmd_e'(s_axis_tuser_i);
    in_item_d.event_time     = s_axis_tdata_i[IN_TIME_LO +: TIME_W];
    in_item_d.buyer_is_maker = s_axis_tdata_i[IN_BIM_LO];
    in_item_d.trade_price    = s_axis_tdata_i[IN_TPX_LO +: PRICE_W];
    in_item_d.trade_qty      = s_axis_tdata_i[IN_TQTY_LO +: QTY_W];
    in_item_d.bid_price      = s_axis_tdata_i[IN_BPX_LO +: PRICE_W];
    in_item_d.bid_qty        = s_axis_tdata_i[IN_BQTY_LO +: QTY_W];
    in_item_d.ask_price      = s_axis_tdata_i[IN_APX_LO +: PRICE_W];
    in_item_d.ask_qty        = s_axis_tdata_i[IN_AQTY_LO +: QTY_W];
  end

  ofe_calc u_calc (
    .item_i   (in_item_q),
    .book_i   (book_q),
    .emit_o   (emit),
    .result_o (calc_res)
  );

  // The held item moves on when it makes no event or the result slot frees up.
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign advance         = in_valid_q && (!emit || out_free);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;

  // Update the book and the event clock as the held item moves on.
  always_comb begin
    book_d = book_q;
    if (advance) begin
      if (in_item_q.cmd == CMD_QUOTE) begin
        book_d.bid_price = in_item_q.bid_price;
        book_d.bid_qty   = in_item_q.bid_qty;
        book_d.ask_price = in_item_q.ask_price;
        book_d.ask_qty   = in_item_q.ask_qty;
        book_d.seeded    = 1'b1;
      end
      if (emit) begin
        book_d.last_time = calc_res.out_time;
      end
    end
  end

  // Result slot: load on an emitting advance, drop after the output transfer.
  always_comb begin
    out_valid_d = out_valid_q && !m_axis_tready_i;
    if (advance && emit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      book_q      <= '0;
    end else begin
      in_valid_q  <= in_xfer || (in_valid_q && !advance);
      out_valid_q <= out_valid_d;
      book_q      <= book_d;
    end
  end

  // Payload registers: hold unless a new value is loaded.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_item_q <= in_item_d;
    end
    if (advance && emit) begin
      out_res_q <= calc_res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_res_q.event_kind;
  assign m_axis_tdata_o  = {{OUT_PAD_W{1'b0}}, out_res_q.out_amount,
                            out_res_q.out_price, out_res_q.out_time};

endmodule
